[rtl/u8f_pkg.sv]
// Shared types and constants for the UTF-8 / escaped-string ASCII folder.
// Used by the front queue, the decoder, the character emitter and the top level.
`default_nettype none

package u8f_pkg;

  localparam int CW_DEFAULT = 16;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] hexv;
  } cbyte_t;

  typedef struct packed {
    cbyte_t cb;
    logic   present;
    logic   last;
  } item_t;

  typedef struct packed {
    logic        term;
    logic        eoi;
    logic        has_term;
    logic [20:0] cp;
  } ev_t;

endpackage

`default_nettype wire

[rtl/u8f_front.sv]
// Front end: accepts input words, works out the hex digit value of each byte
// and holds them in a short queue for the decoder. Depends on u8f_pkg.
`default_nettype none

module u8f_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_byte_present,
  input  logic            in_string_last,
  output logic            q_valid,
  output u8f_pkg::item_t  q_item,
  input  logic            q_pop
);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    if (b >= 8'h30 && b <= 8'h39) return b[3:0];
    if (l >= 8'h61 && l <= 8'h66) return 4'(l - 8'h57);
    return 4'd0;
  endfunction

  u8f_pkg::item_t   mem [QDEPTH];
  logic [QAW-1:0]   wr_r;
  logic [QAW-1:0]   rd_r;
  logic [QAW:0]     cnt_r;
  logic             push;
  u8f_pkg::item_t   in_item;

  assign in_stall = (cnt_r == (QAW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem[rd_r];

  always_comb begin
    in_item.cb.data = in_byte;
    in_item.cb.hexv = hex_val(in_byte);
    in_item.present = in_byte_present;
    in_item.last    = in_string_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (q_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/u8f_decode.sv]
// Decoder: turns queued bytes into code point events, handling escapes, hex
// escapes, surrogate skipping, UTF-8 and the end-of-string flush. Depends on u8f_pkg.
`default_nettype none

module u8f_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  u8f_pkg::item_t  q_item,
  output logic            q_pop,
  input  logic            ev_ready,
  output logic            ev_valid,
  output u8f_pkg::ev_t    ev
);

  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_U  = 8'h75;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [20:0] CP_BAD = 21'h00FFFD;

  typedef enum logic [2:0] {
    M_PLAIN, M_BSLASH, M_HEX, M_SURWAIT, M_SURBS, M_SKIP, M_UTF8
  } mode_t;

  typedef struct packed {
    logic        cp_v;
    logic [20:0] cp;
    mode_t       mode;
    logic [20:0] acc;
    logic [1:0]  cont;
    logic        la_we;
    logic [1:0]  lac;
    logic        done;
    logic        more;
  } feed_t;

  function automatic feed_t feed(input u8f_pkg::cbyte_t cb, input mode_t m,
                                 input logic [20:0] acc, input logic [1:0] cont,
                                 input logic [1:0] lac, input logic [3:0] h0,
                                 input logic [3:0] h1, input logic [3:0] h2);
    feed_t       r;
    logic [7:0]  b;
    mode_t       eff;
    logic [15:0] hx;
    logic [1:0]  c1;
    b      = cb.data;
    r.cp_v = 1'b0;
    r.cp   = '0;
    r.mode = m;
    r.acc  = acc;
    r.cont = cont;
    r.la_we = 1'b0;
    r.lac  = lac;
    r.done = 1'b1;
    r.more = 1'b0;
    hx     = {h0, h1, h2, cb.hexv};
    c1     = (cont != 2'd0) ? cont - 2'd1 : 2'd0;
    eff    = m;
    if (m == M_SURWAIT && b != CH_BS) eff = M_PLAIN;
    if (m == M_SURBS && b != CH_U) eff = M_BSLASH;
    unique case (eff)
      M_PLAIN: begin
        r.mode = M_PLAIN;
        if (b == CH_BS) begin
          r.mode = M_BSLASH;
        end else if (!b[7]) begin
          r.cp_v = 1'b1;
          r.cp   = {13'd0, b};
        end else if (!b[6]) begin
          r.cp_v = 1'b1;
          r.cp   = CP_BAD;
        end else begin
          r.mode = M_UTF8;
          if (b[7:4] == 4'hF) begin
            r.acc  = {18'd0, b[2:0]};
            r.cont = 2'd3;
          end else if (b[7:5] == 3'b111) begin
            r.acc  = {17'd0, b[3:0]};
            r.cont = 2'd2;
          end else begin
            r.acc  = {16'd0, b[4:0]};
            r.cont = 2'd1;
          end
        end
      end
      M_BSLASH: begin
        if (b == CH_U) begin
          r.mode = M_HEX;
          r.lac  = 2'd0;
        end else begin
          r.mode = M_PLAIN;
          r.cp_v = 1'b1;
          r.cp   = (b == CH_N || b == CH_T || b == CH_R) ? {13'd0, CH_SP} : {13'd0, b};
        end
      end
      M_SURWAIT: begin
        r.mode = M_SURBS;
      end
      M_SURBS: begin
        r.mode = M_SKIP;
        r.lac  = 2'd0;
      end
      M_HEX, M_SKIP: begin
        if (lac != 2'd3) begin
          r.la_we = 1'b1;
          r.lac   = lac + 2'd1;
        end else begin
          r.lac = 2'd0;
          if (m == M_SKIP) begin
            r.mode = M_PLAIN;
          end else begin
            r.cp_v = 1'b1;
            r.cp   = {5'd0, hx};
            r.mode = (hx[15:10] == 6'b110110) ? M_SURWAIT : M_PLAIN;
          end
        end
      end
      M_UTF8: begin
        if (b[7:6] == 2'b10) begin
          r.acc  = {acc[14:0], b[5:0]};
          r.cont = c1;
          if (c1 == 2'd0) begin
            r.mode = M_PLAIN;
            r.cp_v = 1'b1;
            r.cp   = {acc[14:0], b[5:0]};
          end
        end else begin
          r.mode = M_PLAIN;
          r.cont = 2'd0;
          r.cp_v = 1'b1;
          r.cp   = acc;
          r.done = 1'b0;
          r.more = (b != CH_BS) && !(b[7] && b[6]);
        end
      end
      default: begin
        r.mode = M_PLAIN;
        r.done = 1'b0;
      end
    endcase
    return r;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [20:0]      acc_r, acc_nxt;
  logic [1:0]       cont_r, cont_nxt;
  logic [1:0]       lac_r, lac_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;
  logic             fin_r, fin_nxt;
  u8f_pkg::cbyte_t  la_r [3];
  u8f_pkg::cbyte_t  la_nxt [3];
  u8f_pkg::cbyte_t  hb_r [3];
  u8f_pkg::cbyte_t  hb_nxt [3];
  u8f_pkg::cbyte_t  src;
  feed_t            fr;
  logic             go;

  always_comb begin
    src = fin_r ? hb_r[0] : q_item.cb;
    fr  = feed(src, mode_r, acc_r, cont_r, lac_r,
               la_r[0].hexv, la_r[1].hexv, la_r[2].hexv);
    go  = q_valid && ev_ready;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cont_nxt = cont_r;
    lac_nxt  = lac_r;
    hcnt_nxt = hcnt_r;
    fin_nxt  = fin_r;
    la_nxt   = la_r;
    hb_nxt   = hb_r;
    q_pop    = 1'b0;
    ev_valid = 1'b0;
    ev       = '0;
    ev.has_term = q_item.last;
    if (go) begin
      if (!fin_r && !q_item.present) begin
        if (q_item.last) begin
          fin_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else if (!fin_r || hcnt_r != 2'd0) begin
        mode_nxt = fr.mode;
        acc_nxt  = fr.acc;
        cont_nxt = fr.cont;
        lac_nxt  = fr.lac;
        if (fr.la_we) begin
          la_nxt[lac_r] = src;
        end
        ev_valid = fr.cp_v;
        ev.cp    = fr.cp;
        ev.eoi   = !q_item.last && (fr.done || !fr.more);
        if (fr.done) begin
          if (fin_r) begin
            hb_nxt[0] = hb_r[1];
            hb_nxt[1] = hb_r[2];
            hcnt_nxt  = hcnt_r - 2'd1;
          end else if (q_item.last) begin
            fin_nxt = 1'b1;
          end else begin
            q_pop = 1'b1;
          end
        end
      end else begin
        unique case (mode_r)
          M_BSLASH, M_SURBS: begin
            ev_valid = 1'b1;
            ev.cp    = {13'd0, CH_BS};
            mode_nxt = M_PLAIN;
          end
          M_HEX, M_SKIP: begin
            ev_valid = 1'b1;
            ev.cp    = {13'd0, CH_U};
            mode_nxt = M_PLAIN;
            hb_nxt   = la_r;
            hcnt_nxt = lac_r;
            lac_nxt  = 2'd0;
          end
          M_UTF8: begin
            ev_valid = 1'b1;
            ev.cp    = acc_r;
            mode_nxt = M_PLAIN;
            cont_nxt = 2'd0;
          end
          default: begin
            ev_valid = 1'b1;
            ev.term  = 1'b1;
            q_pop    = 1'b1;
            fin_nxt  = 1'b0;
            mode_nxt = M_PLAIN;
            acc_nxt  = '0;
            cont_nxt = 2'd0;
            lac_nxt  = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    la_r <= la_nxt;
    hb_r <= hb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      acc_r  <= '0;
      cont_r <= '0;
      lac_r  <= '0;
      hcnt_r <= '0;
      fin_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cont_r <= cont_nxt;
      lac_r  <= lac_nxt;
      hcnt_r <= hcnt_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/u8f_emit.sv]
// Character emitter: folds each code point to one to four ASCII characters,
// applies the output capacity and drives the output register. Depends on u8f_pkg.
`default_nettype none

module u8f_emit #(
  parameter int COUNT_WIDTH = u8f_pkg::CW_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data,
  input  logic           ev_valid,
  input  u8f_pkg::ev_t   ev,
  output logic           ev_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [6:0]     out_char,
  output logic           out_run_last,
  output logic           out_string_end
);

  localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [511:0] L1A =
    {"AAAAAAACEEEEIIIIDNOOOOOxOUUUUYTs", "aaaaaaaceeeeiiiidnooooo/ouuuuyty"};
  localparam logic [1023:0] EXTA =
    {"AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIiJjJjKkk",
     "LlLlLlLlLlNnNnNnnNnOoOoOoOoRrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUu",
     "WwYyYZzZzZzs"};

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][6:0] ch;
  } fold_t;

  function automatic fold_t mk(input logic [31:0] s, input logic [2:0] n);
    fold_t f;
    f.len = n;
    for (int k = 0; k < 4; k++) begin
      f.ch[k] = s[(3-k)*8 +: 7];
    end
    return f;
  endfunction

  function automatic fold_t fold_cp(input logic [20:0] cp);
    fold_t      f;
    logic [7:0] c;
    f = mk("?   ", 3'd1);
    c = 8'd0;
    if (cp < 21'd32) begin
      f = mk("    ", 3'd1);
    end else if (cp < 21'd127) begin
      f = mk({cp[7:0], 24'd0}, 3'd1);
    end else if (cp >= 21'h0C0 && cp <= 21'h0FF) begin
      c = L1A[(63 - 32'(cp[5:0]))*8 +: 8];
      f = mk({c, 24'd0}, 3'd1);
      unique case (cp[5:0])
        6'd6:    f = mk({c, "E", 16'd0}, 3'd2);
        6'd30:   f = mk({c, "h", 16'd0}, 3'd2);
        6'd31:   f = mk({c, "s", 16'd0}, 3'd2);
        6'd38:   f = mk({c, "e", 16'd0}, 3'd2);
        6'd62:   f = mk({c, "h", 16'd0}, 3'd2);
        default: f = mk({c, 24'd0}, 3'd1);
      endcase
    end else if (cp >= 21'h100 && cp <= 21'h17F) begin
      c = EXTA[(127 - 32'(cp[6:0]))*8 +: 8];
      f = mk({c, 24'd0}, 3'd1);
    end else begin
      unique case (cp)
        21'h0A0: f = mk("    ", 3'd1);
        21'h0A9: f = mk("(c) ", 3'd3);
        21'h0AE: f = mk("(R) ", 3'd3);
        21'h0B0: f = mk("deg ", 3'd3);
        21'h0BD: f = mk("1/2 ", 3'd3);
        21'h2018, 21'h2019, 21'h201A, 21'h2032, 21'h0B4: f = mk("'   ", 3'd1);
        21'h201C, 21'h201D, 21'h201E, 21'h2033: f = mk("\"   ", 3'd1);
        21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015,
        21'h2212: f = mk("-   ", 3'd1);
        21'h2026: f = mk("... ", 3'd3);
        21'h2022, 21'h00B7: f = mk("*   ", 3'd1);
        21'h2122: f = mk("(TM)", 3'd4);
        default: f = mk("?   ", 3'd1);
      endcase
    end
    return f;
  endfunction

  logic [15:0]            cap_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt1;
  logic                   evv_r;
  u8f_pkg::ev_t           ev_r;
  logic [1:0]             idx_r;
  logic                   out_valid_r;
  logic [6:0]             out_char_r;
  logic                   out_run_last_r;
  logic                   out_string_end_r;

  fold_t       f;
  logic [15:0] lim;
  logic        can_emit;
  logic        can_next;
  logic        last_char;
  logic        out_ld;
  logic        done;
  logic        push;
  logic        push_char;

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_run_last   = out_run_last_r;
  assign out_string_end = out_string_end_r;

  always_comb begin
    f         = fold_cp(ev_r.cp);
    lim       = (cap_r != 16'd0) ? cap_r - 16'd1 : 16'd0;
    cnt1      = cnt_r + 1'b1;
    can_emit  = (CMPW'(cnt_r) < CMPW'(lim)) && !(&cnt_r);
    can_next  = (CMPW'(cnt1) < CMPW'(lim)) && !(&cnt1);
    last_char = ((3'(idx_r) + 3'd1) == f.len);
    out_ld    = !out_valid_r || !out_stall;
    done      = 1'b0;
    push      = 1'b0;
    push_char = 1'b0;
    if (evv_r) begin
      if (ev_r.term) begin
        if (out_ld) begin
          push = 1'b1;
          done = 1'b1;
        end
      end else if (!can_emit) begin
        done = 1'b1;
      end else if (out_ld) begin
        push      = 1'b1;
        push_char = 1'b1;
        done      = last_char;
      end
    end
    ev_ready = !evv_r || done;
  end

  always_ff @(posedge clk) begin
    if (ev_ready) begin
      ev_r <= ev;
    end
    if (push) begin
      out_char_r       <= ev_r.term ? 7'd0 : f.ch[idx_r];
      out_string_end_r <= ev_r.term;
      out_run_last_r   <= ev_r.term ||
                          (!ev_r.has_term && ((last_char && ev_r.eoi) || !can_next));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= 16'd256;
      cnt_r       <= '0;
      evv_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (push && ev_r.term) begin
        cnt_r <= '0;
      end else if (push_char) begin
        cnt_r <= cnt1;
      end
      if (ev_ready) begin
        evv_r <= ev_valid;
        idx_r <= '0;
      end else if (push_char) begin
        idx_r <= idx_r + 2'd1;
      end
      if (out_ld) begin
        out_valid_r <= push;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_escape_to_ascii_folder.sv]
// Top level of the UTF-8 / escaped-string ASCII folder.
// Instantiates u8f_front, u8f_decode and u8f_emit; depends on u8f_pkg.
//
// Input words carry one byte of string text (in_byte), a flag that the byte
// is present and a flag that marks the last word of the string. Output words
// carry one printable ASCII character, or a zero terminator flagged by
// out_string_end; out_run_last marks the last output word caused by an input
// word. Both channels move a word when valid is high and stall is low.
// The cfg channel writes the output capacity; at most capacity minus one
// characters go out per string before the terminator.
// An input word's first output word passes the input queue, the emitter's
// event register and the output register. While out_stall is low, one input
// word is taken per cycle if each byte folds to at most one character and the
// emitter sends one character per cycle, so a fold into several characters
// holds the decoder until its last one goes, and a byte that cuts a UTF-8
// sequence short is decoded twice. At string end the decoder sends a held
// escape or sequence, each held byte, then the terminator; an empty last word
// first sets the end flag. A two-word input queue and the output register keep
// the input side moving while the receiver stalls. Reset empties the queue,
// returns the decoder to plain text and sets the capacity to 256.
`default_nettype none

module utf8_escape_to_ascii_folder #(
  parameter int COUNT_WIDTH = u8f_pkg::CW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_byte_present,
  input  logic        in_string_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char,
  output logic        out_run_last,
  output logic        out_string_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic            q_valid;
  u8f_pkg::item_t  q_item;
  logic            q_pop;
  logic            ev_valid;
  u8f_pkg::ev_t    ev;
  logic            ev_ready;

  u8f_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_byte_present (in_byte_present),
    .in_string_last  (in_string_last),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  u8f_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .ev_ready (ev_ready),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  u8f_emit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .ev_valid       (ev_valid),
    .ev             (ev),
    .ev_ready       (ev_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire

[rtl/u8f_checker.sv]
// Port-level checker for the ASCII folder, bound to the top level.
// Depends only on the ports of utf8_escape_to_ascii_folder.
`default_nettype none

module u8f_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_char,
  input logic       out_run_last,
  input logic       out_string_end
);

  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_run_last)
    else $error("terminator word without run_last");

  a_term_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_char == 7'd0)
    else $error("terminator word carries a character");

  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_string_end |-> out_char >= 7'h20 && out_char <= 7'h7E)
    else $error("character word is not printable ASCII");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
    $stable(out_string_end))
    else $error("stalled output word changed");

endmodule

bind utf8_escape_to_ascii_folder u8f_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char       (out_char),
  .out_run_last   (out_run_last),
  .out_string_end (out_string_end)
);

`default_nettype wire
